/* rtl/sihm_pkg.sv */
// shared types, widths and saturation helpers of the interval hull merge
package sihm_pkg;

  localparam int unsigned MAX_DIMENSION_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  // depths of the term queue and the result queue
  localparam int unsigned MID_DEPTH = 8;
  localparam int unsigned OUT_DEPTH = 8;

  // arithmetic widths
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned TERM_W = 64;
  localparam int unsigned SUM_W  = TERM_W + 1;
  localparam int unsigned BOX_W  = ACC_W + 1;
  localparam int unsigned VAL_W  = 32;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic                    start_tube;
    logic        [31:0]      star_time;
    logic signed [31:0]      center_value;
    logic signed [31:0]      alpha_value;
    logic signed [31:0]      basis_value;
    logic                    last_term;
    logic                    last_dimension;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]       dim_index;
    logic        [31:0]      start_time;
    logic        [31:0]      end_time;
    logic signed [31:0]      lower_bound;
    logic signed [31:0]      upper_bound;
    logic                    last_of_step;
  } out_item_t;

  // one classified term on its way from the front to the back
  typedef struct packed {
    logic                    start_tube;
    logic                    last_term;
    logic                    last_dimension;
    logic        [31:0]      star_time;
    logic signed [31:0]      center_value;
    logic signed [TERM_W-1:0] term;
  } mid_item_t;

  // clamp a grown sum into the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > SUM_W'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (v < SUM_W'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = ACC_W'(v);
    end
    return r;
  endfunction

  // clamp a box edge into signed 32 bits
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [BOX_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > BOX_W'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (v < BOX_W'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/sihm_ram.sv */
// generic single write port ram with registered read
module sihm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sihm_fifo.sv */
// small register queue with fill count, used between the parts
module sihm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

`ifndef ASSERT_OFF
  // no request is written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < CW'(DEPTH))
    else $error("queue written while full");
  // no request is taken from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");
`endif

endmodule

/* rtl/sihm_front.sv */
// front part: takes requests, forms the rounded term alpha times |basis|
module sihm_front import sihm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  input  logic      mid_pop_i,
  output logic      mid_push_o,
  output mid_item_t mid_data_o
);

  localparam int unsigned CNT_W = $clog2(MID_DEPTH + 1);
  localparam logic [63:0] ROUND = (64'd1 << FRAC_BITS) - 64'd1;

  logic             accept;
  logic [CNT_W-1:0] res_q, res_d;
  logic [31:0]      mag_a, mag_b;

  logic             f1_valid_q, f2_valid_q, f3_valid_q;
  mid_item_t        f1_info_q, f2_info_q, f3_info_q;
  logic [31:0]      f1_mag_a_q, f1_mag_b_q;
  logic             f1_neg_q, f2_neg_q;
  logic [63:0]      f2_prod_q;
  logic [63:0]      ceil_prod;
  logic signed [TERM_W-1:0] term;

  // slots reserved in the term queue: requests in flight plus those queued
  assign accept = push && !full;
  assign full   = (res_q >= CNT_W'(MID_DEPTH));

  always_comb begin
    res_d = res_q;
    if (accept && !mid_pop_i) begin
      res_d = res_q + CNT_W'(1);
    end else if (!accept && mid_pop_i) begin
      res_d = res_q - CNT_W'(1);
    end
  end

  // magnitudes of the operands
  assign mag_a = in_data_i.alpha_value[31] ? (~in_data_i.alpha_value + 32'd1)
                                           : in_data_i.alpha_value;
  assign mag_b = in_data_i.basis_value[31] ? (~in_data_i.basis_value + 32'd1)
                                           : in_data_i.basis_value;

  // shift toward minus infinity: floor for a positive product, ceil then negate
  assign ceil_prod = (f2_prod_q + ROUND) >> FRAC_BITS;
  assign term      = f2_neg_q ? -$signed(ceil_prod) : $signed(f2_prod_q >> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= '0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else begin
      res_q      <= res_d;
      f1_valid_q <= accept;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    f1_info_q  <= '{start_tube:     in_data_i.start_tube,
                    last_term:      in_data_i.last_term,
                    last_dimension: in_data_i.last_dimension,
                    star_time:      in_data_i.star_time,
                    center_value:   in_data_i.center_value,
                    term:           '0};
    f1_mag_a_q <= mag_a;
    f1_mag_b_q <= mag_b;
    f1_neg_q   <= in_data_i.alpha_value[31];

    f2_info_q <= f1_info_q;
    f2_prod_q <= 64'(f1_mag_a_q) * 64'(f1_mag_b_q);
    f2_neg_q  <= f1_neg_q;

    f3_info_q <= '{start_tube:     f2_info_q.start_tube,
                   last_term:      f2_info_q.last_term,
                   last_dimension: f2_info_q.last_dimension,
                   star_time:      f2_info_q.star_time,
                   center_value:   f2_info_q.center_value,
                   term:           term};
  end

  assign mid_push_o = f3_valid_q;
  assign mid_data_o = f3_info_q;

`ifndef ASSERT_OFF
  // reservations never exceed the term queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q <= CNT_W'(MID_DEPTH))
    else $error("term queue over-reserved");
`endif

endmodule

/* rtl/sihm_back.sv */
// back part: accumulates the radius, forms the box and merges with the previous star
module sihm_back import sihm_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mid_empty_i,
  input  mid_item_t mid_data_i,
  output logic      mid_pop_o,
  input  logic      out_pop_i,
  output logic      out_push_o,
  output out_item_t out_data_o
);

  localparam int unsigned DIM_W  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);

  // running state
  logic signed [ACC_W-1:0] acc_q;
  logic [DIM_W-1:0]        dim_q;
  logic                    have_prev_q;
  logic [31:0]             prev_time_q;
  logic [OCNT_W-1:0]       ores_q, ores_d;

  // first step, on the queue head
  logic signed [ACC_W-1:0] acc_base, acc_new;
  logic [DIM_W-1:0]        d_base;
  logic                    hp_eff;
  logic                    b1_go;
  logic                    produce;

  // second step: box of the finished dimension
  logic                    b2_valid_q;
  logic signed [31:0]      b2_center_q;
  logic signed [ACC_W-1:0] b2_acc_q;
  logic [DIM_W-1:0]        b2_dim_q;
  logic                    b2_hp_q;
  logic [31:0]             b2_start_time_q, b2_end_time_q;
  logic                    b2_last_d_q;
  logic                    b2_fwd_q;
  logic [63:0]             b2_fwd_data_q;
  logic signed [31:0]      b2_up, b2_lo;
  logic [63:0]             ram_rdata, prev_box;

  // third step: merge
  logic                    b3_valid_q;
  logic signed [31:0]      b3_up_q, b3_lo_q, b3_prev_up_q, b3_prev_lo_q;
  logic [DIM_W-1:0]        b3_dim_q;
  logic [31:0]             b3_start_time_q, b3_end_time_q;
  logic                    b3_last_d_q;

  // take the next term only with a result slot reserved
  assign mid_pop_o = !mid_empty_i && (ores_q < OCNT_W'(OUT_DEPTH));
  assign b1_go     = mid_pop_o && mid_data_i.last_term;

  // a new tube forgets history before its first term
  assign acc_base = mid_data_i.start_tube ? '0 : acc_q;
  assign d_base   = mid_data_i.start_tube ? '0 : dim_q;
  assign hp_eff   = mid_data_i.start_tube ? 1'b0 : have_prev_q;
  assign acc_new  = sat_acc(SUM_W'(acc_base) + SUM_W'(mid_data_i.term));
  assign produce  = b1_go && hp_eff;

  always_comb begin
    ores_d = ores_q;
    if (produce && !out_pop_i) begin
      ores_d = ores_q + OCNT_W'(1);
    end else if (!produce && out_pop_i) begin
      ores_d = ores_q - OCNT_W'(1);
    end
  end

  // accumulator, dimension count and star history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      dim_q       <= '0;
      have_prev_q <= 1'b0;
      prev_time_q <= '0;
      ores_q      <= '0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
    end else begin
      ores_q     <= ores_d;
      b2_valid_q <= b1_go;
      b3_valid_q <= b2_valid_q && b2_hp_q;
      if (mid_pop_o) begin
        if (!mid_data_i.last_term) begin
          acc_q       <= acc_new;
          dim_q       <= d_base;
          have_prev_q <= hp_eff;
        end else begin
          acc_q <= '0;
          if (mid_data_i.last_dimension) begin
            dim_q       <= '0;
            have_prev_q <= 1'b1;
            prev_time_q <= mid_data_i.star_time;
          end else begin
            dim_q       <= (d_base < DIM_W'(MAX_DIMENSION - 1)) ? d_base + DIM_W'(1)
                                                                 : d_base;
            have_prev_q <= hp_eff;
          end
        end
      end
    end
  end

  // previous box store, read as the dimension finishes
  sihm_ram #(
    .WIDTH (64),
    .DEPTH (MAX_DIMENSION),
    .AW    (DIM_W)
  ) u_prev_box (
    .clk_i   (clk_i),
    .we_i    (b2_valid_q),
    .waddr_i (b2_dim_q),
    .wdata_i ({b2_up, b2_lo}),
    .raddr_i (d_base),
    .rdata_o (ram_rdata)
  );

  // capture the finished dimension, with a bypass for a write to the same entry
  always_ff @(posedge clk_i) begin
    if (b1_go) begin
      b2_center_q     <= mid_data_i.center_value;
      b2_acc_q        <= acc_new;
      b2_dim_q        <= d_base;
      b2_hp_q         <= hp_eff;
      b2_start_time_q <= prev_time_q;
      b2_end_time_q   <= mid_data_i.star_time;
      b2_last_d_q     <= mid_data_i.last_dimension;
      b2_fwd_q        <= b2_valid_q && (b2_dim_q == d_base);
      b2_fwd_data_q   <= {b2_up, b2_lo};
    end
  end

  // box edges, saturated
  assign b2_up    = sat_val(BOX_W'(b2_center_q) + BOX_W'(b2_acc_q));
  assign b2_lo    = sat_val(BOX_W'(b2_center_q) - BOX_W'(b2_acc_q));
  assign prev_box = b2_fwd_q ? b2_fwd_data_q : ram_rdata;

  always_ff @(posedge clk_i) begin
    b3_up_q         <= b2_up;
    b3_lo_q         <= b2_lo;
    b3_prev_up_q    <= prev_box[63:32];
    b3_prev_lo_q    <= prev_box[31:0];
    b3_dim_q        <= b2_dim_q;
    b3_start_time_q <= b2_start_time_q;
    b3_end_time_q   <= b2_end_time_q;
    b3_last_d_q     <= b2_last_d_q;
  end

  // merged box towards the result queue
  always_comb begin
    out_data_o.dim_index    = 3'(b3_dim_q);
    out_data_o.start_time   = b3_start_time_q;
    out_data_o.end_time     = b3_end_time_q;
    out_data_o.lower_bound  = (b3_prev_lo_q < b3_lo_q) ? b3_prev_lo_q : b3_lo_q;
    out_data_o.upper_bound  = (b3_prev_up_q > b3_up_q) ? b3_prev_up_q : b3_up_q;
    out_data_o.last_of_step = b3_last_d_q;
  end

  assign out_push_o = b3_valid_q;

`ifndef ASSERT_OFF
  // result slots reserved never exceed the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ores_q <= OCNT_W'(OUT_DEPTH))
    else $error("result queue over-reserved");
  // a finished dimension with a previous star leads to a merged result through the second and third steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> ##1 out_push_o)
    else $error("merged result lost in the pipeline");
`endif

endmodule

/* rtl/star_interval_hull_merge.sv */
// interval hull merge of a star stream: results pass the front, the term queue, the back and the result queue
// throughput one term request per cycle while full is low, set by the radius add-and-saturate in the back part
// a finished dimension also takes one read and one write of the previous box store
// reset clears the queues, pipeline valids, accumulator, dimension count and history flag
// the previous box store is not cleared: its entries are undefined until written
module star_interval_hull_merge import sihm_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF,
  parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  localparam int unsigned MCNT_W = $clog2(MID_DEPTH + 1);
  localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);

  logic              mid_push, mid_pop, mid_empty;
  mid_item_t         mid_wdata, mid_rdata;
  logic [MCNT_W-1:0] mid_count;
  logic              out_push, out_pop;
  out_item_t         out_wdata;
  logic [OCNT_W-1:0] out_count;

  // front: term forming
  sihm_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .mid_pop_i  (mid_pop),
    .mid_push_o (mid_push),
    .mid_data_o (mid_wdata)
  );

  // term queue between the parts
  sihm_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // back: accumulate, box and merge
  sihm_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_pop_i   (out_pop),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata)
  );

  // result queue
  assign out_pop = pop && !empty;

  sihm_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .pop_i   (out_pop),
    .rdata_o (out_data_o),
    .empty_o (empty),
    .count_o (out_count)
  );

`ifndef ASSERT_OFF
  // neither the term queue nor the result queue holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_count <= MCNT_W'(MID_DEPTH) && out_count <= OCNT_W'(OUT_DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule
